### hdl/jcsl_pkg.sv
package jcsl_pkg;

	localparam int ARM_JOINTS = 6;
	localparam int POS_WIDTH = 20;
	localparam int NUM_JOINTS = ARM_JOINTS + 1;
	localparam int JOINT_W = $clog2(NUM_JOINTS + 1);
	localparam int JIDX_W = $clog2(NUM_JOINTS);

	localparam int VEL_W = 20;
	localparam int LEAD_W = 19;
	localparam int TRAVEL_W = 19;
	localparam int SCALE_W = 24;
	localparam int POLICY_W = 3;
	localparam int MODE_W = 8;
	localparam int PERIOD_W = 20;
	localparam int CMD_W = 24;
	localparam int OUTCOME_W = 2;

	// The period counts units of 2^-20 s, so the step product drops 20 fraction bits.
	localparam int PERIOD_FRAC = 20;
	localparam int LIM_W = VEL_W + PERIOD_W - PERIOD_FRAC;
	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(5243);

	// The gripper scale is Q8.16.
	localparam int SCALE_FRAC = 16;
	localparam int GRIP_W = POS_WIDTH - 1;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_MAX_VELOCITY = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MAX_LEAD = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_GRIP_TRAVEL = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_GRIPPER_SCALE = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_MERGE_POLICY = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_COMMAND_MODE = REG_IDX_W'(5);

	localparam logic [POLICY_W-1:0] MERGE_MEAN = POLICY_W'(0);
	localparam logic [POLICY_W-1:0] MERGE_FIRST = POLICY_W'(1);
	localparam logic [POLICY_W-1:0] MERGE_SECOND = POLICY_W'(2);
	localparam logic [POLICY_W-1:0] MERGE_MAX = POLICY_W'(3);
	localparam logic [POLICY_W-1:0] MERGE_MIN = POLICY_W'(4);

	typedef enum logic [OUTCOME_W-1:0] {
		OUTCOME_SENT = 2'd0,
		OUTCOME_STALE = 2'd1,
		OUTCOME_ERROR = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [VEL_W-1:0] max_velocity;
		logic [LEAD_W-1:0] max_lead;
		logic [TRAVEL_W-1:0] grip_travel;
		logic [SCALE_W-1:0] gripper_scale;
		logic [POLICY_W-1:0] merge_policy;
		logic [MODE_W-1:0] command_mode;
	} cfg_t;

	typedef struct packed {
		logic [JOINT_W-1:0] joint;
		logic signed [POS_WIDTH-1:0] target;
		logic signed [POS_WIDTH-1:0] measured;
		logic [LIM_W-1:0] lim;
		logic [GRIP_W-1:0] grip_pos;
		logic fresh;
		logic valid;
	} item_t;

endpackage

### hdl/joint_command_slew_limiter.sv
// Joint command slew limiter: each command transfer carries one joint's target and measured
// position and yields exactly one result transfer, in order. Arm joints move their last sent
// position toward the target by at most max_velocity * period, stay within max_lead of the
// measured position and saturate to the position range; the gripper joint merges its two
// finger targets, clamps to zero through the travel limit and scales to a command. The block
// takes one command per cycle while cmd_stall is low; a result is presented once its command
// has passed the input register, the step-limit and finger-merge stage and then the stage that
// reads and updates the per-joint state into the result register. The state update sits in that
// last stage, so commands for the same joint may follow each other back to back. Registers are
// written through the APB port and should only change while no command is in flight.
module joint_command_slew_limiter (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [jcsl_pkg::ADDR_W-1:0] paddr,
	input logic [jcsl_pkg::DATA_W-1:0] pwdata,
	output logic [jcsl_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [jcsl_pkg::JOINT_W-1:0] joint,
	input logic signed [jcsl_pkg::POS_WIDTH-1:0] target,
	input logic signed [jcsl_pkg::POS_WIDTH-1:0] target_second,
	input logic signed [jcsl_pkg::POS_WIDTH-1:0] measured,
	input logic [jcsl_pkg::PERIOD_W-1:0] period,
	input logic status_ok,
	input logic target_valid,
	output logic res_valid,
	input logic res_stall,
	output logic [jcsl_pkg::JOINT_W-1:0] joint_out,
	output logic signed [jcsl_pkg::POS_WIDTH-1:0] sent_position,
	output logic [jcsl_pkg::CMD_W-1:0] gripper_command,
	output logic [jcsl_pkg::OUTCOME_W-1:0] outcome,
	output logic [jcsl_pkg::MODE_W-1:0] mode_out
);

	jcsl_pkg::cfg_t cfg;
	jcsl_pkg::item_t item_s2;
	logic vld_s2;
	logic take_s2;

	jcsl_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	jcsl_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.joint(joint),
		.target(target),
		.target_second(target_second),
		.measured(measured),
		.period(period),
		.status_ok(status_ok),
		.target_valid(target_valid),
		.take_s2(take_s2),
		.vld_s2(vld_s2),
		.item_s2(item_s2)
	);

	jcsl_update u_update (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.vld_s2(vld_s2),
		.item_s2(item_s2),
		.take_s2(take_s2),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.joint_out(joint_out),
		.sent_position(sent_position),
		.gripper_command(gripper_command),
		.outcome(outcome),
		.mode_out(mode_out)
	);

endmodule

### hdl/jcsl_regs.sv
module jcsl_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [jcsl_pkg::ADDR_W-1:0] paddr,
	input logic [jcsl_pkg::DATA_W-1:0] pwdata,
	output logic [jcsl_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output jcsl_pkg::cfg_t cfg
);

	logic [jcsl_pkg::REG_IDX_W-1:0] idx;
	logic wr_en;
	jcsl_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign idx = paddr[jcsl_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_velocity <= jcsl_pkg::VEL_W'(65536);
			cfg_q.max_lead <= jcsl_pkg::LEAD_W'(13107);
			cfg_q.grip_travel <= jcsl_pkg::TRAVEL_W'(65536);
			cfg_q.gripper_scale <= jcsl_pkg::SCALE_W'(65536);
			cfg_q.merge_policy <= jcsl_pkg::MERGE_MEAN;
			cfg_q.command_mode <= '0;
		end else if (wr_en) begin
			case (idx)
				jcsl_pkg::REG_MAX_VELOCITY: begin
					cfg_q.max_velocity <= pwdata[jcsl_pkg::VEL_W-1:0];
				end
				jcsl_pkg::REG_MAX_LEAD: begin
					cfg_q.max_lead <= pwdata[jcsl_pkg::LEAD_W-1:0];
				end
				jcsl_pkg::REG_GRIP_TRAVEL: begin
					cfg_q.grip_travel <= pwdata[jcsl_pkg::TRAVEL_W-1:0];
				end
				jcsl_pkg::REG_GRIPPER_SCALE: begin
					cfg_q.gripper_scale <= pwdata[jcsl_pkg::SCALE_W-1:0];
				end
				jcsl_pkg::REG_MERGE_POLICY: begin
					cfg_q.merge_policy <= pwdata[jcsl_pkg::POLICY_W-1:0];
				end
				jcsl_pkg::REG_COMMAND_MODE: begin
					cfg_q.command_mode <= pwdata[jcsl_pkg::MODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			jcsl_pkg::REG_MAX_VELOCITY: prdata = jcsl_pkg::DATA_W'(cfg_q.max_velocity);
			jcsl_pkg::REG_MAX_LEAD: prdata = jcsl_pkg::DATA_W'(cfg_q.max_lead);
			jcsl_pkg::REG_GRIP_TRAVEL: prdata = jcsl_pkg::DATA_W'(cfg_q.grip_travel);
			jcsl_pkg::REG_GRIPPER_SCALE: prdata = jcsl_pkg::DATA_W'(cfg_q.gripper_scale);
			jcsl_pkg::REG_MERGE_POLICY: prdata = jcsl_pkg::DATA_W'(cfg_q.merge_policy);
			jcsl_pkg::REG_COMMAND_MODE: prdata = jcsl_pkg::DATA_W'(cfg_q.command_mode);
			default: prdata = '0;
		endcase
	end

endmodule

### hdl/jcsl_prep.sv
module jcsl_prep (
	input logic clk,
	input logic arst_n,
	input jcsl_pkg::cfg_t cfg,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [jcsl_pkg::JOINT_W-1:0] joint,
	input logic signed [jcsl_pkg::POS_WIDTH-1:0] target,
	input logic signed [jcsl_pkg::POS_WIDTH-1:0] target_second,
	input logic signed [jcsl_pkg::POS_WIDTH-1:0] measured,
	input logic [jcsl_pkg::PERIOD_W-1:0] period,
	input logic status_ok,
	input logic target_valid,
	input logic take_s2,
	output logic vld_s2,
	output jcsl_pkg::item_t item_s2
);

	localparam int PROD_W = jcsl_pkg::VEL_W + jcsl_pkg::PERIOD_W;
	localparam int SUM_W = jcsl_pkg::POS_WIDTH + 1;
	localparam int CMP_W = ((jcsl_pkg::TRAVEL_W > jcsl_pkg::POS_WIDTH) ?
		jcsl_pkg::TRAVEL_W : jcsl_pkg::POS_WIDTH) + 1;

	logic vld_s1;
	logic [jcsl_pkg::JOINT_W-1:0] joint_s1;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] target_s1;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] second_s1;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] measured_s1;
	logic [jcsl_pkg::PERIOD_W-1:0] period_s1;
	logic fresh_s1;
	logic valid_s1;

	logic ready_s1;
	logic ready_s2;
	logic [jcsl_pkg::PERIOD_W-1:0] period_eff;
	logic [PROD_W-1:0] step_prod;
	logic signed [SUM_W-1:0] finger_sum;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] merged;
	logic [CMP_W-1:0] merged_u;
	logic [CMP_W-1:0] travel_u;
	logic [jcsl_pkg::GRIP_W-1:0] grip_pos;
	jcsl_pkg::item_t item_d;

	assign ready_s2 = !vld_s2 || take_s2;
	assign ready_s1 = !vld_s1 || ready_s2;
	assign cmd_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				vld_s1 <= cmd_valid;
			end
			if (ready_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && ready_s1) begin
			joint_s1 <= joint;
			target_s1 <= target;
			second_s1 <= target_second;
			measured_s1 <= measured;
			period_s1 <= period;
			fresh_s1 <= status_ok;
			valid_s1 <= target_valid;
		end
		if (vld_s1 && ready_s2) begin
			item_s2 <= item_d;
		end
	end

	// Step limit: max_velocity * period (a zero period uses the default), fraction bits dropped.
	assign period_eff = (period_s1 == '0) ? jcsl_pkg::DEFAULT_PERIOD : period_s1;
	assign step_prod = PROD_W'(cfg.max_velocity) * PROD_W'(period_eff);

	// The mean rounds toward minus infinity, which an arithmetic shift gives.
	assign finger_sum = SUM_W'(target_s1) + SUM_W'(second_s1);

	always_comb begin
		case (cfg.merge_policy)
			jcsl_pkg::MERGE_FIRST: merged = target_s1;
			jcsl_pkg::MERGE_SECOND: merged = second_s1;
			jcsl_pkg::MERGE_MAX: merged = (target_s1 > second_s1) ? target_s1 : second_s1;
			jcsl_pkg::MERGE_MIN: merged = (target_s1 < second_s1) ? target_s1 : second_s1;
			default: merged = finger_sum[SUM_W-1:1];
		endcase
	end

	// A non-negative merged value already fits the position range, so the
	// smaller of it and the travel needs no further saturation.
	assign merged_u = CMP_W'(unsigned'(merged));
	assign travel_u = CMP_W'(cfg.grip_travel);

	always_comb begin
		if (merged < 0) begin
			grip_pos = '0;
		end else if (travel_u < merged_u) begin
			grip_pos = travel_u[jcsl_pkg::GRIP_W-1:0];
		end else begin
			grip_pos = merged_u[jcsl_pkg::GRIP_W-1:0];
		end
	end

	always_comb begin
		item_d.joint = joint_s1;
		item_d.target = target_s1;
		item_d.measured = measured_s1;
		item_d.lim = step_prod[PROD_W-1:jcsl_pkg::PERIOD_FRAC];
		item_d.grip_pos = grip_pos;
		item_d.fresh = fresh_s1;
		item_d.valid = valid_s1;
	end

endmodule

### hdl/jcsl_update.sv
module jcsl_update (
	input logic clk,
	input logic arst_n,
	input jcsl_pkg::cfg_t cfg,
	input logic vld_s2,
	input jcsl_pkg::item_t item_s2,
	output logic take_s2,
	output logic res_valid,
	input logic res_stall,
	output logic [jcsl_pkg::JOINT_W-1:0] joint_out,
	output logic signed [jcsl_pkg::POS_WIDTH-1:0] sent_position,
	output logic [jcsl_pkg::CMD_W-1:0] gripper_command,
	output logic [jcsl_pkg::OUTCOME_W-1:0] outcome,
	output logic [jcsl_pkg::MODE_W-1:0] mode_out
);

	localparam int W = ((jcsl_pkg::LIM_W > jcsl_pkg::POS_WIDTH) ?
		jcsl_pkg::LIM_W : jcsl_pkg::POS_WIDTH) + 3;
	localparam int GPROD_W = jcsl_pkg::GRIP_W + jcsl_pkg::SCALE_W;
	localparam int GSHIFT_W = GPROD_W - jcsl_pkg::SCALE_FRAC;

	logic signed [jcsl_pkg::POS_WIDTH-1:0] last_q [jcsl_pkg::NUM_JOINTS];
	logic [jcsl_pkg::NUM_JOINTS-1:0] ready_q;
	logic res_valid_q;

	logic ready_out;
	logic [jcsl_pkg::JIDX_W-1:0] jidx;
	logic in_range;
	logic is_grip;
	logic accept_ok;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] last;
	logic signed [W-1:0] diff;
	logic signed [W-1:0] lim_w;
	logic signed [W-1:0] step;
	logic signed [W-1:0] pos;
	logic signed [W-1:0] lead_lo;
	logic signed [W-1:0] lead_hi;
	logic signed [W-1:0] pos_lead;
	logic signed [W-1:0] pos_max;
	logic signed [W-1:0] pos_min;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] arm_pos;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] grip_sent;
	logic [GPROD_W-1:0] gprod;
	logic [GSHIFT_W-1:0] gshift;
	logic [jcsl_pkg::CMD_W-1:0] gcmd;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] sent_d;
	logic [jcsl_pkg::CMD_W-1:0] gcmd_d;
	jcsl_pkg::outcome_t outcome_d;

	assign ready_out = !res_valid_q || !res_stall;
	assign take_s2 = vld_s2 && ready_out;
	assign res_valid = res_valid_q;

	assign jidx = item_s2.joint[jcsl_pkg::JIDX_W-1:0];
	assign in_range = item_s2.joint <= jcsl_pkg::JOINT_W'(jcsl_pkg::ARM_JOINTS);
	assign is_grip = item_s2.joint == jcsl_pkg::JOINT_W'(jcsl_pkg::ARM_JOINTS);
	assign accept_ok = item_s2.fresh && item_s2.valid && in_range;

	// A joint that has not been initialized starts from its measured position.
	assign last = ready_q[jidx] ? last_q[jidx] : item_s2.measured;

	assign diff = W'(item_s2.target) - W'(last);
	assign lim_w = W'(item_s2.lim);
	assign lead_lo = W'(item_s2.measured) - W'(cfg.max_lead);
	assign lead_hi = W'(item_s2.measured) + W'(cfg.max_lead);
	assign pos_max = W'({1'b0, {(jcsl_pkg::POS_WIDTH-1){1'b1}}});
	assign pos_min = -pos_max - W'(1);

	always_comb begin
		if (diff < -lim_w) begin
			step = -lim_w;
		end else if (diff > lim_w) begin
			step = lim_w;
		end else begin
			step = diff;
		end
		pos = W'(last) + step;
		if (pos < lead_lo) begin
			pos_lead = lead_lo;
		end else if (pos > lead_hi) begin
			pos_lead = lead_hi;
		end else begin
			pos_lead = pos;
		end
		if (pos_lead < pos_min) begin
			arm_pos = pos_min[jcsl_pkg::POS_WIDTH-1:0];
		end else if (pos_lead > pos_max) begin
			arm_pos = pos_max[jcsl_pkg::POS_WIDTH-1:0];
		end else begin
			arm_pos = pos_lead[jcsl_pkg::POS_WIDTH-1:0];
		end
	end

	assign grip_sent = jcsl_pkg::POS_WIDTH'(item_s2.grip_pos);
	assign gprod = GPROD_W'(item_s2.grip_pos) * GPROD_W'(cfg.gripper_scale);
	assign gshift = gprod[GPROD_W-1:jcsl_pkg::SCALE_FRAC];
	assign gcmd = (gshift > GSHIFT_W'({jcsl_pkg::CMD_W{1'b1}})) ?
		{jcsl_pkg::CMD_W{1'b1}} : gshift[jcsl_pkg::CMD_W-1:0];

	always_comb begin
		sent_d = '0;
		gcmd_d = '0;
		if (!item_s2.fresh) begin
			outcome_d = jcsl_pkg::OUTCOME_STALE;
		end else if (!accept_ok) begin
			outcome_d = jcsl_pkg::OUTCOME_ERROR;
		end else begin
			outcome_d = jcsl_pkg::OUTCOME_SENT;
			if (is_grip) begin
				sent_d = grip_sent;
				gcmd_d = gcmd;
			end else begin
				sent_d = arm_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			ready_q <= '0;
		end else begin
			if (ready_out) begin
				res_valid_q <= vld_s2;
			end
			if (take_s2) begin
				if (!item_s2.fresh) begin
					ready_q <= '0;
				end else if (accept_ok) begin
					ready_q[jidx] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s2) begin
			if (accept_ok) begin
				last_q[jidx] <= sent_d;
			end
			joint_out <= item_s2.joint;
			sent_position <= sent_d;
			gripper_command <= gcmd_d;
			outcome <= outcome_d;
			mode_out <= cfg.command_mode;
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_CMDS = 165;
	localparam longint POS_HI = (longint'(1) <<< (jcsl_pkg::POS_WIDTH - 1)) - 1;
	localparam longint POS_LO = -POS_HI - 1;
	localparam longint CMD_HI = (longint'(1) <<< jcsl_pkg::CMD_W) - 1;

	typedef struct {
		logic [jcsl_pkg::JOINT_W-1:0] joint;
		logic signed [jcsl_pkg::POS_WIDTH-1:0] target;
		logic signed [jcsl_pkg::POS_WIDTH-1:0] second;
		logic signed [jcsl_pkg::POS_WIDTH-1:0] measured;
		logic [jcsl_pkg::PERIOD_W-1:0] period;
		logic fresh;
		logic valid;
	} joint_cmd_t;

	typedef struct {
		logic [jcsl_pkg::JOINT_W-1:0] joint;
		logic signed [jcsl_pkg::POS_WIDTH-1:0] sent;
		logic [jcsl_pkg::CMD_W-1:0] grip_cmd;
		jcsl_pkg::outcome_t outcome;
		logic [jcsl_pkg::MODE_W-1:0] mode;
	} joint_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [jcsl_pkg::ADDR_W-1:0] paddr = '0;
	logic [jcsl_pkg::DATA_W-1:0] pwdata = '0;
	logic [jcsl_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [jcsl_pkg::JOINT_W-1:0] joint_out;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] sent_position;
	logic [jcsl_pkg::CMD_W-1:0] gripper_command;
	logic [jcsl_pkg::OUTCOME_W-1:0] outcome;
	logic [jcsl_pkg::MODE_W-1:0] mode_out;

	joint_cmd_t drv_cmd = '{default: '0};

	// Register copies and per-joint state of the limiter.
	logic [jcsl_pkg::VEL_W-1:0] cfg_velocity = jcsl_pkg::VEL_W'(65536);
	logic [jcsl_pkg::LEAD_W-1:0] cfg_lead = jcsl_pkg::LEAD_W'(13107);
	logic [jcsl_pkg::TRAVEL_W-1:0] cfg_travel = jcsl_pkg::TRAVEL_W'(65536);
	logic [jcsl_pkg::SCALE_W-1:0] cfg_scale = jcsl_pkg::SCALE_W'(65536);
	logic [jcsl_pkg::POLICY_W-1:0] cfg_policy = jcsl_pkg::MERGE_MEAN;
	logic [jcsl_pkg::MODE_W-1:0] cfg_mode = '0;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] held_pos [jcsl_pkg::NUM_JOINTS];
	logic [jcsl_pkg::NUM_JOINTS-1:0] ready_mask = '0;
	logic signed [jcsl_pkg::POS_WIDTH-1:0] track_meas [jcsl_pkg::NUM_JOINTS];

	joint_cmd_t pending_cmds [$];
	joint_result_t expected_results [$];

	logic cmd_took = 1'b0;
	bit no_idle = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int errors = 0;
	int cmds_accepted = 0;
	int results_checked = 0;
	int n_sent = 0;
	int n_stale = 0;
	int n_rejected = 0;
	int n_gripper = 0;
	int reg_writes = 0;

	joint_command_slew_limiter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.joint(drv_cmd.joint),
		.target(drv_cmd.target),
		.target_second(drv_cmd.second),
		.measured(drv_cmd.measured),
		.period(drv_cmd.period),
		.status_ok(drv_cmd.fresh),
		.target_valid(drv_cmd.valid),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.joint_out(joint_out),
		.sent_position(sent_position),
		.gripper_command(gripper_command),
		.outcome(outcome),
		.mode_out(mode_out)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count++;

	function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic joint_result_t predict_command(input joint_cmd_t c);
		joint_result_t r;
		longint tgt, sec, meas, last, lim, pos, lead, per, prod;
		r.joint = c.joint;
		r.sent = '0;
		r.grip_cmd = '0;
		r.outcome = jcsl_pkg::OUTCOME_SENT;
		r.mode = cfg_mode;
		if (!c.fresh) begin
			ready_mask = '0;
			r.outcome = jcsl_pkg::OUTCOME_STALE;
		end else if (!c.valid || c.joint > jcsl_pkg::ARM_JOINTS) begin
			r.outcome = jcsl_pkg::OUTCOME_ERROR;
		end else begin
			tgt = longint'(c.target);
			sec = longint'(c.second);
			meas = longint'(c.measured);
			lead = longint'(cfg_lead);
			if (!ready_mask[c.joint]) begin
				held_pos[c.joint] = c.measured;
				ready_mask[c.joint] = 1'b1;
			end
			last = longint'(held_pos[c.joint]);
			if (c.joint < jcsl_pkg::ARM_JOINTS) begin
				per = (c.period == '0) ? longint'(jcsl_pkg::DEFAULT_PERIOD) :
					longint'(c.period);
				lim = (longint'(cfg_velocity) * per) >>> jcsl_pkg::PERIOD_FRAC;
				pos = last + clamp_range(tgt - last, -lim, lim);
				pos = clamp_range(pos, meas - lead, meas + lead);
				pos = clamp_range(pos, POS_LO, POS_HI);
			end else begin
				case (cfg_policy)
					jcsl_pkg::MERGE_FIRST: pos = tgt;
					jcsl_pkg::MERGE_SECOND: pos = sec;
					jcsl_pkg::MERGE_MAX: pos = (tgt > sec) ? tgt : sec;
					jcsl_pkg::MERGE_MIN: pos = (tgt < sec) ? tgt : sec;
					default: pos = (tgt + sec) >>> 1;
				endcase
				pos = clamp_range(pos, 0, longint'(cfg_travel));
				pos = clamp_range(pos, POS_LO, POS_HI);
				prod = (pos * longint'(cfg_scale)) >>> jcsl_pkg::SCALE_FRAC;
				r.grip_cmd = (prod > CMD_HI) ? '1 : prod[jcsl_pkg::CMD_W-1:0];
			end
			held_pos[c.joint] = pos[jcsl_pkg::POS_WIDTH-1:0];
			r.sent = pos[jcsl_pkg::POS_WIDTH-1:0];
		end
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
		end
	endtask

	// Prediction at the command transfer, checking at the result transfer.
	always @(posedge clk) begin
		joint_result_t want;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				expected_results.insert(expected_results.size(), predict_command(drv_cmd));
				cmds_accepted++;
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result for joint %0d with none expected", $time, joint_out);
				end else begin
					want = expected_results.pop_front();
					compare_field("joint_out", 32'(want.joint), 32'(joint_out));
					compare_field("sent_position", 32'(want.sent), 32'(sent_position));
					compare_field("gripper_command", 32'(want.grip_cmd),
						32'(gripper_command));
					compare_field("outcome", 32'(want.outcome), 32'(outcome));
					compare_field("mode_out", 32'(want.mode), 32'(mode_out));
					results_checked++;
					case (want.outcome)
						jcsl_pkg::OUTCOME_SENT: n_sent++;
						jcsl_pkg::OUTCOME_STALE: n_stale++;
						default: n_rejected++;
					endcase
					if (want.joint == jcsl_pkg::ARM_JOINTS &&
							want.outcome == jcsl_pkg::OUTCOME_SENT)
						n_gripper++;
				end
			end
		end
		cmd_took <= arst_n && cmd_valid && !cmd_stall;
	end

	function automatic int idle_length();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_took) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				drv_cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
				gap_left = idle_length();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
			if ($urandom_range(0, 2) == 0)
				stall_left = idle_length();
		end
	end

	task automatic wait_for_drain();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0);
	endtask

	// Write one register, then read it back; only done with nothing in flight.
	task automatic write_register(input logic [jcsl_pkg::REG_IDX_W-1:0] idx,
			input logic [jcsl_pkg::DATA_W-1:0] value);
		logic [jcsl_pkg::DATA_W-1:0] back, want;
		wait_for_drain();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		back = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			jcsl_pkg::REG_MAX_VELOCITY: begin
				cfg_velocity = value[jcsl_pkg::VEL_W-1:0];
				want = jcsl_pkg::DATA_W'(cfg_velocity);
			end
			jcsl_pkg::REG_MAX_LEAD: begin
				cfg_lead = value[jcsl_pkg::LEAD_W-1:0];
				want = jcsl_pkg::DATA_W'(cfg_lead);
			end
			jcsl_pkg::REG_GRIP_TRAVEL: begin
				cfg_travel = value[jcsl_pkg::TRAVEL_W-1:0];
				want = jcsl_pkg::DATA_W'(cfg_travel);
			end
			jcsl_pkg::REG_GRIPPER_SCALE: begin
				cfg_scale = value[jcsl_pkg::SCALE_W-1:0];
				want = jcsl_pkg::DATA_W'(cfg_scale);
			end
			jcsl_pkg::REG_MERGE_POLICY: begin
				cfg_policy = value[jcsl_pkg::POLICY_W-1:0];
				want = jcsl_pkg::DATA_W'(cfg_policy);
			end
			jcsl_pkg::REG_COMMAND_MODE: begin
				cfg_mode = value[jcsl_pkg::MODE_W-1:0];
				want = jcsl_pkg::DATA_W'(cfg_mode);
			end
			default: begin
				want = '0;
			end
		endcase
		reg_writes++;
		compare_field("register readback", want, back);
	endtask

	task automatic set_config(input longint vel, input longint lead, input longint travel,
			input longint scale, input logic [jcsl_pkg::POLICY_W-1:0] policy,
			input longint mode);
		write_register(jcsl_pkg::REG_MAX_VELOCITY, vel[jcsl_pkg::DATA_W-1:0]);
		write_register(jcsl_pkg::REG_MAX_LEAD, lead[jcsl_pkg::DATA_W-1:0]);
		write_register(jcsl_pkg::REG_GRIP_TRAVEL, travel[jcsl_pkg::DATA_W-1:0]);
		write_register(jcsl_pkg::REG_GRIPPER_SCALE, scale[jcsl_pkg::DATA_W-1:0]);
		write_register(jcsl_pkg::REG_MERGE_POLICY, jcsl_pkg::DATA_W'(policy));
		write_register(jcsl_pkg::REG_COMMAND_MODE, mode[jcsl_pkg::DATA_W-1:0]);
	endtask

	task automatic push_cmd(input int j, input longint t, input longint s, input longint m,
			input longint p, input bit f, input bit v);
		joint_cmd_t c;
		c.joint = j[jcsl_pkg::JOINT_W-1:0];
		c.target = t[jcsl_pkg::POS_WIDTH-1:0];
		c.second = s[jcsl_pkg::POS_WIDTH-1:0];
		c.measured = m[jcsl_pkg::POS_WIDTH-1:0];
		c.period = p[jcsl_pkg::PERIOD_W-1:0];
		c.fresh = f;
		c.valid = v;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	function automatic longint extreme_pos();
		case ($urandom_range(0, 4))
			0: return POS_HI;
			1: return POS_LO;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic longint rand_pos();
		logic signed [jcsl_pkg::POS_WIDTH-1:0] v;
		v = jcsl_pkg::POS_WIDTH'($urandom);
		return longint'(v);
	endfunction

	// Mostly plausible motion: each joint's measured position drifts and an arm joint's target stays
	// near it, so the step limit and the lead clamp both get exercised without saturating.
	function automatic joint_cmd_t random_command();
		joint_cmd_t c;
		int j, roll;
		longint m, t, s;
		j = $urandom_range(0, jcsl_pkg::ARM_JOINTS);
		roll = $urandom_range(0, 9);
		if (roll == 0)
			m = extreme_pos();
		else if (roll == 1)
			m = rand_pos();
		else
			m = clamp_range(longint'(track_meas[j]) + longint'($urandom_range(0, 4000)) - 2000,
				POS_LO, POS_HI);
		track_meas[j] = m[jcsl_pkg::POS_WIDTH-1:0];
		if (j == jcsl_pkg::ARM_JOINTS) begin
			t = longint'($urandom_range(0, int'(cfg_travel) + 2000)) - 1000;
			s = t + longint'($urandom_range(0, 4000)) - 2000;
		end else begin
			t = m + longint'($urandom_range(0, 1200)) - 600;
			s = rand_pos();
		end
		roll = $urandom_range(0, 9);
		if (roll == 0)
			t = extreme_pos();
		else if (roll == 1)
			t = rand_pos();
		else if (roll == 2)
			t = m + longint'($urandom_range(0, 60000)) - 30000;
		if ($urandom_range(0, 9) == 0)
			s = rand_pos();
		c.joint = j[jcsl_pkg::JOINT_W-1:0];
		c.target = jcsl_pkg::POS_WIDTH'(clamp_range(t, POS_LO, POS_HI));
		c.second = jcsl_pkg::POS_WIDTH'(clamp_range(s, POS_LO, POS_HI));
		c.measured = m[jcsl_pkg::POS_WIDTH-1:0];
		case ($urandom_range(0, 9))
			0: c.period = '0;
			1: c.period = '1;
			2: c.period = jcsl_pkg::PERIOD_W'($urandom);
			3: c.period = jcsl_pkg::PERIOD_W'($urandom_range(1, 16));
			default: c.period = jcsl_pkg::PERIOD_W'($urandom_range(4000, 7000));
		endcase
		c.fresh = 1'b1;
		c.valid = 1'b1;
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			c.fresh = 1'b0;
		end else if (roll < 4) begin
			c.fresh = 1'b0;
			c.valid = 1'b0;
		end else if (roll < 8) begin
			c.valid = 1'b0;
		end else if (roll < 10) begin
			c.joint = jcsl_pkg::JOINT_W'(jcsl_pkg::NUM_JOINTS);
		end
		return c;
	endfunction

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		longint vel, lead, travel, scale;
		for (int k = 0; k < jcsl_pkg::NUM_JOINTS; k++) begin
			held_pos[k] = '0;
			track_meas[k] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed commands at the reset register values.
		push_cmd(0, 100000, 0, 0, 0, 1, 1);
		push_cmd(0, 100000, 0, 0, 0, 1, 1);
		push_cmd(1, POS_HI, 0, POS_HI, 1048575, 1, 1);
		push_cmd(1, POS_LO, 0, POS_HI, 1, 1, 1);
		push_cmd(2, POS_LO, 0, POS_LO, 1048575, 1, 1);
		push_cmd(jcsl_pkg::ARM_JOINTS, POS_HI, POS_LO, 0, 0, 1, 1);
		push_cmd(jcsl_pkg::ARM_JOINTS, 30001, 40000, 0, 0, 1, 1);
		push_cmd(jcsl_pkg::ARM_JOINTS, POS_HI, POS_HI, 0, 0, 1, 1);
		push_cmd(jcsl_pkg::NUM_JOINTS, 5, 5, 5, 5, 1, 1);
		push_cmd(3, 5, 0, 0, 0, 1, 0);
		push_cmd(4, 5, 0, 0, 0, 0, 1);
		push_cmd(5, 5, 0, 0, 0, 0, 0);
		push_cmd(0, 100000, 0, 2000, 0, 1, 1);

		set_config(1048575, 524287, 524287, 16777215, jcsl_pkg::MERGE_MAX, 255);
		push_cmd(jcsl_pkg::ARM_JOINTS, POS_HI, 100, 0, 0, 1, 1);
		push_cmd(0, POS_HI, 0, POS_LO, 1048575, 1, 1);
		push_cmd(1, POS_LO, 0, POS_HI, 1048575, 1, 1);
		write_register(jcsl_pkg::REG_MERGE_POLICY, jcsl_pkg::DATA_W'(jcsl_pkg::MERGE_FIRST));
		push_cmd(jcsl_pkg::ARM_JOINTS, 1000, 2000, 0, 0, 1, 1);
		write_register(jcsl_pkg::REG_MERGE_POLICY, jcsl_pkg::DATA_W'(jcsl_pkg::MERGE_SECOND));
		push_cmd(jcsl_pkg::ARM_JOINTS, 1000, 2000, 0, 0, 1, 1);
		write_register(jcsl_pkg::REG_MERGE_POLICY, jcsl_pkg::DATA_W'(jcsl_pkg::MERGE_MIN));
		push_cmd(jcsl_pkg::ARM_JOINTS, 1000, 2000, 0, 0, 1, 1);
		// Policy codes past the last defined one fall back to the mean.
		write_register(jcsl_pkg::REG_MERGE_POLICY,
			jcsl_pkg::DATA_W'(jcsl_pkg::MERGE_MIN + 1));
		push_cmd(jcsl_pkg::ARM_JOINTS, 1001, 2000, 0, 0, 1, 1);

		// Zero lead and zero travel pin the outputs to measured and to zero.
		set_config(0, 0, 0, 0, '1, 8'h5A);
		push_cmd(0, 1000, 0, 500, 0, 1, 1);
		push_cmd(jcsl_pkg::ARM_JOINTS, 1000, 1000, 0, 0, 1, 1);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			vel = (p == 1) ? 0 : (p == 2) ? 1048575 :
				longint'($urandom_range(1000, 400000));
			lead = (p == 3) ? 0 : (p == 4) ? 524287 : longint'($urandom_range(200, 60000));
			travel = (p == 5) ? 0 : (p == 6) ? 524287 :
				longint'($urandom_range(1000, 200000));
			scale = (p == 7) ? 0 : (p == 8) ? 16777215 :
				longint'($urandom_range(0, 16777215));
			set_config(vel, lead, travel, scale, p[jcsl_pkg::POLICY_W-1:0],
				longint'($urandom_range(0, 255)));
			no_idle = (p % 3 == 2);
			for (int n = 0; n < PHASE_CMDS; n++)
				pending_cmds.insert(pending_cmds.size(), random_command());
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors += expected_results.size();
			$display("%0t: %0d results never arrived", $time, expected_results.size());
		end
		$display("summary: %0d commands, %0d results checked (%0d sent, %0d stale, %0d rejected)",
			cmds_accepted, results_checked, n_sent, n_stale, n_rejected);
		$display("summary: %0d gripper commands sent, %0d register writes, all merge policies",
			n_gripper, reg_writes);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### files.f
hdl/jcsl_pkg.sv
hdl/jcsl_regs.sv
hdl/jcsl_prep.sv
hdl/jcsl_update.sv
hdl/joint_command_slew_limiter.sv
tb/testbench.sv
